### rtl/gbcm_pkg.sv
// gbcm_pkg: shared types, constants and round functions for the gost block cipher modes
// used by gbcm_front, gbcm_queue, gbcm_engine and the top level gost_block_cipher_modes
// no dependencies
package gbcm_pkg;

  // stream and configuration widths
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned TDATA_W     = 72;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ROUND_W     = 5;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned KEY_IDX_W   = 3;
  localparam int unsigned MODE_W      = 2;

  // default depth of the command queue between front and engine
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_SEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR = 3'd6;

  // cipher_mode register codes
  localparam logic [MODE_W-1:0] MODE_SIMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFB     = 2'd2;

  // gamma stepping constants
  localparam logic [31:0] GAMMA_C1 = 32'h0101_0101;
  localparam logic [31:0] GAMMA_C2 = 32'h0101_0104;
  localparam logic [31:0] GAMMA_MOD_HI = 32'hFFFF_FFFF;

  // fixed s-box set, row r indexed by nibble value
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // operation picked by the front for each block
  typedef enum logic [2:0] {
    OP_ECB_ENC,
    OP_ECB_DEC,
    OP_COUNTER,
    OP_OFB,
    OP_PASS
  } gbcm_op_e;

  // engine sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_STEP,
    S_ROUND,
    S_HOLD
  } gbcm_state_e;

  // one classified block travelling from front to engine
  typedef struct packed {
    logic [BLOCK_W-1:0] data;
    logic [COUNT_W-1:0] count;
    logic               restart;
    gbcm_op_e           op;
  } gbcm_cmd_t;

  // one feistel round: n1 + k, s-boxes, rotate left 11, mix into n2, shift halves
  function automatic logic [63:0] gbcm_round(input logic [63:0] blk, input logic [31:0] k);
    logic [31:0] s;
    logic [31:0] t;
    s = blk[31:0] + k;
    for (int i = 0; i < 8; i++) begin
      t[4*i +: 4] = SBOX[7-i][s[4*i +: 4]];
    end
    return {blk[31:0], blk[63:32] ^ {t[20:0], t[31:21]}};
  endfunction

  // counter gamma step: low half + c1 mod 2^32, high half + c2 mod 2^32-1
  function automatic logic [63:0] gbcm_gamma_step(input logic [63:0] g);
    logic [31:0] lo;
    logic [32:0] sum;
    logic [32:0] fold;
    lo   = g[31:0] + GAMMA_C1;
    sum  = {1'b0, g[63:32]} + {1'b0, GAMMA_C2};
    // 2^32 is 1 mod 2^32-1, so fold the carry back in
    fold = {1'b0, sum[31:0]} + {32'd0, sum[32]};
    if (fold >= {1'b0, GAMMA_MOD_HI}) begin
      fold = fold - {1'b0, GAMMA_MOD_HI};
    end
    return {fold[31:0], lo};
  endfunction

endpackage

### rtl/gbcm_queue.sv
// gbcm_queue: short command queue between the front and the cipher engine
// depends on gbcm_pkg for the command type
module gbcm_queue #(
  parameter int unsigned DEPTH = gbcm_pkg::QUEUE_DEPTH_DEF  // 2 and up
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gbcm_pkg::gbcm_cmd_t push_cmd_i,
  input  logic                pop_i,
  output gbcm_pkg::gbcm_cmd_t head_cmd_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gbcm_pkg::gbcm_cmd_t entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/gbcm_front.sv
// gbcm_front: accepts input stream transactions and classifies each block by mode
// depends on gbcm_pkg for the command type, field widths and mode codes
module gbcm_front (
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gbcm_pkg::TDATA_W-1:0]        s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic [gbcm_pkg::MODE_W-1:0]         cipher_mode_i,
  input  logic                                decrypt_sel_i,
  input  logic                                queue_full_i,
  output logic                                push_o,
  output gbcm_pkg::gbcm_cmd_t                 push_cmd_o
);

  gbcm_pkg::gbcm_op_e op;

  // pick the engine operation from the current mode registers
  always_comb begin
    unique case (cipher_mode_i)
      gbcm_pkg::MODE_SIMPLE:  op = decrypt_sel_i ? gbcm_pkg::OP_ECB_DEC : gbcm_pkg::OP_ECB_ENC;
      gbcm_pkg::MODE_COUNTER: op = gbcm_pkg::OP_COUNTER;
      gbcm_pkg::MODE_OFB:     op = gbcm_pkg::OP_OFB;
      default:                op = gbcm_pkg::OP_PASS;
    endcase
  end

  assign s_axis_tready = !queue_full_i;
  assign push_o        = s_axis_tvalid && !queue_full_i;

  always_comb begin
    push_cmd_o.data    = s_axis_tdata[gbcm_pkg::BLOCK_W-1:0];
    push_cmd_o.count   = s_axis_tdata[gbcm_pkg::BLOCK_W +: gbcm_pkg::COUNT_W];
    push_cmd_o.restart = s_axis_tuser;
    push_cmd_o.op      = op;
  end

endmodule

### rtl/gbcm_engine.sv
// gbcm_engine: round-per-cycle gost cipher sequencer, gamma register and output register
// depends on gbcm_pkg for the round function, gamma step, command type and state type
module gbcm_engine (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [gbcm_pkg::KEY_WORDS-1:0][31:0]          key_i,
  input  logic [gbcm_pkg::BLOCK_W-1:0]                  init_vector_i,
  input  logic                                          queue_empty_i,
  input  gbcm_pkg::gbcm_cmd_t                           head_cmd_i,
  output logic                                          pop_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [gbcm_pkg::BLOCK_W-1:0]                  out_block_o,
  output logic [gbcm_pkg::COUNT_W-1:0]                  out_count_o
);

  gbcm_pkg::gbcm_state_e state_q, state_d;
  logic [gbcm_pkg::ROUND_W-1:0] rnd_q, rnd_d;
  logic [gbcm_pkg::BLOCK_W-1:0] blk_q, blk_d;
  logic [gbcm_pkg::BLOCK_W-1:0] gamma_q, gamma_d;
  gbcm_pkg::gbcm_cmd_t          cmd_q, cmd_d;
  logic                         out_valid_q, out_valid_d;
  logic [gbcm_pkg::BLOCK_W-1:0] out_block_q, out_block_d;
  logic [gbcm_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  logic                           rev_order;
  logic [gbcm_pkg::KEY_IDX_W-1:0] key_idx;
  logic [gbcm_pkg::BLOCK_W-1:0]   rnd_out;
  logic [gbcm_pkg::BLOCK_W-1:0]   ciph;
  logic [gbcm_pkg::BLOCK_W-1:0]   gamma_next;
  logic                           last_rnd;
  logic                           out_free;

  // key schedule: forward words except the reversed tail, decrypt mirrors it
  always_comb begin
    if (state_q == gbcm_pkg::S_ROUND && cmd_q.op == gbcm_pkg::OP_ECB_DEC) begin
      rev_order = (rnd_q[4:3] != 2'b00);
    end else begin
      rev_order = (rnd_q[4:3] == 2'b11);
    end
    key_idx = rev_order ? ~rnd_q[2:0] : rnd_q[2:0];
  end

  assign rnd_out    = gbcm_pkg::gbcm_round(blk_q, key_i[key_idx]);
  assign ciph       = {rnd_out[31:0], rnd_out[63:32]};
  assign gamma_next = gbcm_pkg::gbcm_gamma_step(gamma_q);
  assign last_rnd   = &rnd_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_o      = (state_q == gbcm_pkg::S_IDLE) && !queue_empty_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbcm_pkg::S_IDLE: begin
        if (!queue_empty_i) begin
          unique case (head_cmd_i.op)
            gbcm_pkg::OP_PASS:    state_d = gbcm_pkg::S_HOLD;
            gbcm_pkg::OP_COUNTER: state_d = head_cmd_i.restart ? gbcm_pkg::S_INIT
                                                                : gbcm_pkg::S_STEP;
            default:              state_d = gbcm_pkg::S_ROUND;
          endcase
        end
      end
      gbcm_pkg::S_INIT:  if (last_rnd) state_d = gbcm_pkg::S_STEP;
      gbcm_pkg::S_STEP:  state_d = gbcm_pkg::S_ROUND;
      gbcm_pkg::S_ROUND: if (last_rnd) state_d = gbcm_pkg::S_HOLD;
      gbcm_pkg::S_HOLD:  if (out_free) state_d = gbcm_pkg::S_IDLE;
      default:           state_d = gbcm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rnd_d       = rnd_q;
    blk_d       = blk_q;
    gamma_d     = gamma_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_block_d = out_block_q;
    out_count_d = out_count_q;
    unique case (state_q)
      gbcm_pkg::S_IDLE: begin
        if (!queue_empty_i) begin
          cmd_d = head_cmd_i;
          rnd_d = '0;
          unique case (head_cmd_i.op)
            gbcm_pkg::OP_COUNTER: blk_d = init_vector_i;
            gbcm_pkg::OP_OFB:     blk_d = head_cmd_i.restart ? init_vector_i : gamma_q;
            default:              blk_d = head_cmd_i.data;
          endcase
        end
      end
      gbcm_pkg::S_INIT: begin
        rnd_d = rnd_q + 1'b1;
        blk_d = rnd_out;
        if (last_rnd) begin
          gamma_d = ciph;
        end
      end
      gbcm_pkg::S_STEP: begin
        rnd_d   = '0;
        gamma_d = gamma_next;
        blk_d   = gamma_next;
      end
      gbcm_pkg::S_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        blk_d = rnd_out;
        if (last_rnd) begin
          unique case (cmd_q.op)
            gbcm_pkg::OP_COUNTER: blk_d = cmd_q.data ^ ciph;
            gbcm_pkg::OP_OFB: begin
              blk_d   = cmd_q.data ^ ciph;
              gamma_d = ciph;
            end
            default:              blk_d = ciph;
          endcase
        end
      end
      gbcm_pkg::S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_block_d = blk_q;
          out_count_d = cmd_q.count;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbcm_pkg::S_IDLE;
      rnd_q       <= '0;
      gamma_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      gamma_q     <= gamma_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q       <= blk_d;
    cmd_q       <= cmd_d;
    out_block_q <= out_block_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_block_o = out_block_q;
  assign out_count_o = out_count_q;

endmodule

### rtl/gost_block_cipher_modes.sv
// gost_block_cipher_modes: top level of the gost 28147-89 cipher in three modes
// depends on gbcm_pkg, gbcm_front, gbcm_queue and gbcm_engine

// GOST 28147-89 64-bit block cipher with a 256-bit key and the fixed s-box set.
// cipher_mode 0 enciphers each block (or deciphers with decrypt_sel), mode 1 xors
// data with the encrypted counter gamma, mode 2 xors data with output feedback
// gamma, the unused mode 3 passes data through. a block with tuser set restarts
// the gamma from init_vector. one result transaction comes out per input
// transaction, in order, with the byte count passed through; short blocks are
// processed whole. one shared round unit does one feistel round per cycle; in
// counter mode with restart it first encrypts the init vector to seed the gamma.
// a command queue of QUEUE_DEPTH blocks lets the input side run ahead while the
// engine works, and a result register lets the engine start the next block while
// a result waits. the user writes configuration only while the block is idle;
// the block itself does not enforce this.
module gost_block_cipher_modes #(
  parameter int unsigned QUEUE_DEPTH = gbcm_pkg::QUEUE_DEPTH_DEF  // 2 and up
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gbcm_pkg::TDATA_W-1:0]        s_axis_tdata,   // data_block, byte_count, zeros
  input  logic                                s_axis_tuser,   // restart
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [gbcm_pkg::TDATA_W-1:0]        m_axis_tdata,   // result_block, valid_bytes, zeros
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [gbcm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbcm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [63:0]                     key_pair_0_q, key_pair_1_q, key_pair_2_q, key_pair_3_q;
  logic [gbcm_pkg::MODE_W-1:0]     cipher_mode_q;
  logic                            decrypt_sel_q;
  logic [gbcm_pkg::BLOCK_W-1:0]    init_vector_q;

  logic [gbcm_pkg::KEY_WORDS-1:0][31:0] key_words;

  // front to queue to engine
  logic                 push;
  gbcm_pkg::gbcm_cmd_t  push_cmd;
  logic                 pop;
  gbcm_pkg::gbcm_cmd_t  head_cmd;
  logic                 queue_full;
  logic                 queue_empty;

  logic [gbcm_pkg::BLOCK_W-1:0] out_block;
  logic [gbcm_pkg::COUNT_W-1:0] out_count;

  // register writes, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pair_0_q  <= '0;
      key_pair_1_q  <= '0;
      key_pair_2_q  <= '0;
      key_pair_3_q  <= '0;
      cipher_mode_q <= gbcm_pkg::MODE_SIMPLE;
      decrypt_sel_q <= 1'b0;
      init_vector_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbcm_pkg::CFG_KEY_PAIR_0:  key_pair_0_q  <= cfg_data_i;
        gbcm_pkg::CFG_KEY_PAIR_1:  key_pair_1_q  <= cfg_data_i;
        gbcm_pkg::CFG_KEY_PAIR_2:  key_pair_2_q  <= cfg_data_i;
        gbcm_pkg::CFG_KEY_PAIR_3:  key_pair_3_q  <= cfg_data_i;
        gbcm_pkg::CFG_CIPHER_MODE: cipher_mode_q <= cfg_data_i[gbcm_pkg::MODE_W-1:0];
        gbcm_pkg::CFG_DECRYPT_SEL: decrypt_sel_q <= cfg_data_i[0];
        gbcm_pkg::CFG_INIT_VECTOR: init_vector_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key word i sits in pair i/2, even words in the low half
  assign key_words = {key_pair_3_q, key_pair_2_q, key_pair_1_q, key_pair_0_q};

  gbcm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cipher_mode_i (cipher_mode_q),
    .decrypt_sel_i (decrypt_sel_q),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  gbcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .full_o     (queue_full),
    .empty_o    (queue_empty)
  );

  gbcm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         (key_words),
    .init_vector_i (init_vector_q),
    .queue_empty_i (queue_empty),
    .head_cmd_i    (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_block_o   (out_block),
    .out_count_o   (out_count)
  );

  // result packing, upper pad bits are zero
  assign m_axis_tdata = {
    {(gbcm_pkg::TDATA_W - gbcm_pkg::BLOCK_W - gbcm_pkg::COUNT_W){1'b0}},
    out_count,
    out_block
  };

endmodule
